// ===== design/raster_run_stream_checker_macros.svh =====
// --------------------------------------------------------------------------
// raster run stream checker assertion macros
// shared concurrent assertion forms used by the port checker
// --------------------------------------------------------------------------
`ifndef RASTER_RUN_STREAM_CHECKER_MACROS_SVH
`define RASTER_RUN_STREAM_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RRSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrsc_pkg.sv =====
// --------------------------------------------------------------------------
// rrsc_pkg
// shared types and constants of the raster run stream checker
// --------------------------------------------------------------------------
package rrsc_pkg;

    // configuration port
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd2;

    // pixel unit size and run payload counter
    localparam int PIX_W     = 4;
    localparam int PAYLOAD_W = 11;

    // request commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_PAGE = 1'b1;

    // run control coding
    localparam logic [7:0] CTRL_ESCAPE  = 8'h80;
    localparam logic [8:0] LITERAL_BASE = 9'd257;

    typedef enum logic [1:0] {
        ROLE_REPEAT  = 2'd0,
        ROLE_CONTROL = 2'd1,
        ROLE_PAYLOAD = 2'd2
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CTRL128 = 3'd1,
        ERR_ROWS    = 3'd2,
        ERR_LINE    = 3'd3,
        ERR_NO_PAGE = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] data_out;
        t_role      byte_role;
        logic       line_done;
        logic       page_done;
        t_err       error_code;
    } t_result;

endpackage

// ===== design/rrsc_in_if.sv =====
// --------------------------------------------------------------------------
// rrsc_in_if
// request channel: begin-page commands and compressed stream bytes
// --------------------------------------------------------------------------
interface rrsc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== design/rrsc_out_if.sv =====
// --------------------------------------------------------------------------
// rrsc_out_if
// result channel: passed-through bytes with role, progress and error
// --------------------------------------------------------------------------
interface rrsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [1:0] byte_role;
    logic       line_done;
    logic       page_done;
    logic [2:0] error_code;

    modport source (output valid, output data_out, output byte_role, output line_done,
                    output page_done, output error_code, input ready);
    modport sink   (input valid, input data_out, input byte_role, input line_done,
                    input page_done, input error_code, output ready);
endinterface

// ===== design/raster_run_stream_checker.sv =====
// a stream byte is held in the input register, then its result in the result register
// throughput: one request per cycle by the core's parse step, unless a result is stalled
// a begin-page request takes one slot of the input register and gives no result
// reset (synchronous, active low): no page open, counters and sticky error cleared,
//   page_height, line_bytes and pixel_bytes back to 1
// --------------------------------------------------------------------------
// raster_run_stream_checker
// checks a packbits-style raster page stream byte by byte and passes the
// bytes through tagged with role, row progress and a sticky error code
// --------------------------------------------------------------------------
module raster_run_stream_checker #(
    parameter int MAX_LINE_BYTES  = 262144,
    parameter int MAX_PAGE_ROWS   = 262144,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [rrsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rrsc_pkg::CFG_W-1:0]      i_cfg_data,
    // request and result channels
    rrsc_in_if.sink                         i_in,
    rrsc_out_if.source                      o_out
);
    localparam int RW = $clog2(MAX_PAGE_ROWS + 1);
    localparam int LW = $clog2(MAX_LINE_BYTES + 1);

    // clamped configuration
    logic [RW-1:0]              eff_height;
    logic [LW-1:0]              eff_line;
    logic [rrsc_pkg::PIX_W-1:0] eff_pixel;

    // input register
    logic                       r_s1_valid;
    logic                       r_s1_cmd;
    logic [7:0]                 r_s1_byte;

    // result register
    logic                       r_out_valid;
    rrsc_pkg::t_result          r_out;

    rrsc_pkg::t_result          step_result;
    logic                       out_free;
    logic                       step;
    logic                       in_take;

    rrsc_cfg #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PAGE_ROWS   (MAX_PAGE_ROWS),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_eff_height (eff_height),
        .o_eff_line   (eff_line),
        .o_eff_pixel  (eff_pixel)
    );

    // result register is free when empty or drained this cycle
    assign out_free = !r_out_valid || o_out.ready;

    // a held request moves through the core when its result has a place;
    // begin-page never produces a result, so it never waits
    assign step     = r_s1_valid && ((r_s1_cmd == rrsc_pkg::CMD_PAGE) || out_free);

    // input register refills in the same cycle it empties
    assign i_in.ready = !r_s1_valid || step;
    assign in_take    = i_in.valid && i_in.ready;

    rrsc_core #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_PAGE_ROWS  (MAX_PAGE_ROWS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_command    (r_s1_cmd),
        .i_data_byte  (r_s1_byte),
        .i_eff_height (eff_height),
        .i_eff_line   (eff_line),
        .i_eff_pixel  (eff_pixel),
        .o_result     (step_result)
    );

    // input register: valid under reset, payload loads on each take without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (step) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd  <= i_in.command;
            r_s1_byte <= i_in.data_byte;
        end
    end

    // result register: loads on every stream byte step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (r_s1_cmd == rrsc_pkg::CMD_BYTE)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (r_s1_cmd == rrsc_pkg::CMD_BYTE)) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data_out   = r_out.data_out;
    assign o_out.byte_role  = r_out.byte_role;
    assign o_out.line_done  = r_out.line_done;
    assign o_out.page_done  = r_out.page_done;
    assign o_out.error_code = r_out.error_code;
endmodule

// ===== design/rrsc_cfg.sv =====
// --------------------------------------------------------------------------
// rrsc_cfg
// configuration registers, stored already clamped to the supported range
// --------------------------------------------------------------------------
module rrsc_cfg #(
    parameter int MAX_LINE_BYTES  = 262144,
    parameter int MAX_PAGE_ROWS   = 262144,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [rrsc_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [rrsc_pkg::CFG_W-1:0]                i_cfg_data,
    output logic [$clog2(MAX_PAGE_ROWS+1)-1:0]        o_eff_height,
    output logic [$clog2(MAX_LINE_BYTES+1)-1:0]       o_eff_line,
    output logic [rrsc_pkg::PIX_W-1:0]                o_eff_pixel
);
    localparam int RW  = $clog2(MAX_PAGE_ROWS + 1);
    localparam int LW  = $clog2(MAX_LINE_BYTES + 1);
    localparam int HCW = (RW > rrsc_pkg::CFG_W) ? RW : rrsc_pkg::CFG_W;
    localparam int LCW = (LW > rrsc_pkg::CFG_W) ? LW : rrsc_pkg::CFG_W;

    logic [RW-1:0]              r_height, n_height;
    logic [LW-1:0]              r_line, n_line;
    logic [rrsc_pkg::PIX_W-1:0] r_pixel, n_pixel;
    logic [HCW-1:0]             wr_height;
    logic [LCW-1:0]             wr_line;
    logic [rrsc_pkg::PIX_W-1:0] wr_pixel;

    assign wr_height = HCW'(i_cfg_data);
    assign wr_line   = LCW'(i_cfg_data);
    assign wr_pixel  = i_cfg_data[rrsc_pkg::PIX_W-1:0];

    // saturate to the limits, pixel size zero counts as one
    assign n_height = (wr_height > HCW'(MAX_PAGE_ROWS)) ? RW'(MAX_PAGE_ROWS) : RW'(wr_height);
    assign n_line   = (wr_line > LCW'(MAX_LINE_BYTES)) ? LW'(MAX_LINE_BYTES) : LW'(wr_line);

    always_comb begin
        if (wr_pixel == '0) begin
            n_pixel = rrsc_pkg::PIX_W'(1);
        end else if (wr_pixel > rrsc_pkg::PIX_W'(MAX_PIXEL_BYTES)) begin
            n_pixel = rrsc_pkg::PIX_W'(MAX_PIXEL_BYTES);
        end else begin
            n_pixel = wr_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= RW'(1);
            r_line   <= LW'(1);
            r_pixel  <= rrsc_pkg::PIX_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrsc_pkg::REG_PAGE_HEIGHT: r_height <= n_height;
                rrsc_pkg::REG_LINE_BYTES:  r_line   <= n_line;
                rrsc_pkg::REG_PIXEL_BYTES: r_pixel  <= n_pixel;
                default: ;
            endcase
        end
    end

    assign o_eff_height = r_height;
    assign o_eff_line   = r_line;
    assign o_eff_pixel  = r_pixel;
endmodule

// ===== design/rrsc_core.sv =====
// --------------------------------------------------------------------------
// rrsc_core
// stream parse state and the per-byte check, one byte per step
// --------------------------------------------------------------------------
module rrsc_core #(
    parameter int MAX_LINE_BYTES = 262144,
    parameter int MAX_PAGE_ROWS  = 262144
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_step,
    input  logic                                  i_command,
    input  logic [7:0]                            i_data_byte,
    input  logic [$clog2(MAX_PAGE_ROWS+1)-1:0]    i_eff_height,
    input  logic [$clog2(MAX_LINE_BYTES+1)-1:0]   i_eff_line,
    input  logic [rrsc_pkg::PIX_W-1:0]            i_eff_pixel,
    output rrsc_pkg::t_result                     o_result
);
    localparam int RW   = $clog2(MAX_PAGE_ROWS + 1);
    localparam int LW   = $clog2(MAX_LINE_BYTES + 1);
    localparam int RSW  = ((RW > 9) ? RW : 9) + 1;
    localparam int SUMW = ((LW > rrsc_pkg::PAYLOAD_W) ? LW : rrsc_pkg::PAYLOAD_W) + 1;
    localparam int PW   = rrsc_pkg::PAYLOAD_W;

    typedef enum logic [2:0] {
        PH_NONE, PH_REPEAT, PH_CONTROL, PH_PAYLOAD, PH_DONE, PH_ERROR
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [RW-1:0]     r_rows, n_rows;
    logic [8:0]        r_pend, n_pend;
    logic [LW-1:0]     r_fill, n_fill;
    logic [PW-1:0]     r_pl, n_pl;
    rrsc_pkg::t_err    r_err, n_err;

    logic              literal;
    logic [7:0]        units;
    logic [PW-1:0]     expanded;
    logic [PW-1:0]     pl_dec;
    logic [8:0]        count;
    logic [8:0]        rows_add;
    logic [RSW-1:0]    rows_sum;
    logic [SUMW-1:0]   fill_sum;
    rrsc_pkg::t_role   role;
    logic              line_done;
    logic              page_done;

    // run length of the control byte, in pixel units and in bytes
    assign literal  = i_data_byte[7];
    assign units    = literal ? 8'(rrsc_pkg::LITERAL_BASE - {1'b0, i_data_byte})
                              : 8'(i_data_byte + 8'd1);
    assign expanded = PW'(units) * PW'(i_eff_pixel);
    assign fill_sum = SUMW'(r_fill) + SUMW'(expanded);

    // rows covered by a repeat byte, or by the group being closed
    assign count    = {1'b0, i_data_byte} + 9'd1;
    assign rows_add = (r_phase == PH_REPEAT) ? count : r_pend;
    assign rows_sum = RSW'(r_rows) + RSW'(rows_add);

    assign pl_dec   = (r_pl != '0) ? r_pl - PW'(1) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_rows    = r_rows;
        n_pend    = r_pend;
        n_fill    = r_fill;
        n_pl      = r_pl;
        n_err     = r_err;
        role      = rrsc_pkg::ROLE_REPEAT;
        line_done = 1'b0;
        page_done = 1'b0;

        unique case (r_phase)
            PH_ERROR: ;
            PH_NONE, PH_DONE: begin
                n_err   = rrsc_pkg::ERR_NO_PAGE;
                n_phase = PH_ERROR;
            end
            PH_REPEAT: begin
                if (rows_sum > RSW'(i_eff_height)) begin
                    n_err   = rrsc_pkg::ERR_ROWS;
                    n_phase = PH_ERROR;
                end else begin
                    n_pend = count;
                    n_fill = '0;
                    // zero line length closes the group at once
                    if (i_eff_line == '0) begin
                        line_done = 1'b1;
                        n_rows    = RW'(rows_sum);
                        n_pend    = '0;
                        if (rows_sum >= RSW'(i_eff_height)) begin
                            page_done = 1'b1;
                            n_phase   = PH_DONE;
                        end
                    end else begin
                        n_phase = PH_CONTROL;
                    end
                end
            end
            PH_CONTROL: begin
                role = rrsc_pkg::ROLE_CONTROL;
                if (i_data_byte == rrsc_pkg::CTRL_ESCAPE) begin
                    n_err   = rrsc_pkg::ERR_CTRL128;
                    n_phase = PH_ERROR;
                end else if (fill_sum > SUMW'(i_eff_line)) begin
                    n_err   = rrsc_pkg::ERR_LINE;
                    n_phase = PH_ERROR;
                end else begin
                    n_pl    = literal ? expanded : PW'(i_eff_pixel);
                    n_fill  = LW'(fill_sum);
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role = rrsc_pkg::ROLE_PAYLOAD;
                n_pl = pl_dec;
                if (pl_dec == '0) begin
                    if (r_fill >= i_eff_line) begin
                        line_done = 1'b1;
                        n_rows    = RW'(rows_sum);
                        n_pend    = '0;
                        n_fill    = '0;
                        if (rows_sum >= RSW'(i_eff_height)) begin
                            page_done = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_REPEAT;
                        end
                    end else begin
                        n_phase = PH_CONTROL;
                    end
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        // begin page wipes everything, sticky error too
        if (i_command == rrsc_pkg::CMD_PAGE) begin
            n_phase = PH_REPEAT;
            n_rows  = '0;
            n_pend  = '0;
            n_fill  = '0;
            n_pl    = '0;
            n_err   = rrsc_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_rows  <= '0;
            r_pend  <= '0;
            r_fill  <= '0;
            r_pl    <= '0;
            r_err   <= rrsc_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_rows  <= n_rows;
            r_pend  <= n_pend;
            r_fill  <= n_fill;
            r_pl    <= n_pl;
            r_err   <= n_err;
        end
    end

    assign o_result.data_out   = i_data_byte;
    assign o_result.byte_role  = role;
    assign o_result.line_done  = line_done;
    assign o_result.page_done  = page_done;
    assign o_result.error_code = n_err;
endmodule

// ===== design/rrsc_checker.sv =====
// --------------------------------------------------------------------------
// rrsc_checker
// port-level checks on the result channel of the raster run stream checker
// --------------------------------------------------------------------------
`include "raster_run_stream_checker_macros.svh"

module rrsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_out,
    input logic [1:0] i_byte_role,
    input logic       i_line_done,
    input logic       i_page_done,
    input logic [2:0] i_error_code
);
    // stalled result holds
    `RRSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_data_out) && $stable(i_error_code), "result changed while stalled")

    // finishing the page always finishes a row group
    `RRSC_ASSERT_SAME(a_page_line, i_clk, i_rst_n, i_out_valid && i_page_done, i_line_done, "page done without line done")

    // errored bytes never report progress
    `RRSC_ASSERT_SAME(a_err_quiet, i_clk, i_rst_n, i_out_valid && (i_error_code != rrsc_pkg::ERR_NONE), !i_line_done && !i_page_done, "progress flagged on errored byte")

    // payload bytes cannot raise or carry an error
    `RRSC_ASSERT_SAME(a_err_role, i_clk, i_rst_n, i_out_valid && (i_error_code != rrsc_pkg::ERR_NONE), i_byte_role != rrsc_pkg::ROLE_PAYLOAD, "payload role with error")

    // row group completion only on a repeat byte or the last payload byte
    `RRSC_ASSERT_SAME(a_done_role, i_clk, i_rst_n, i_out_valid && i_line_done, (i_byte_role == rrsc_pkg::ROLE_REPEAT) || (i_byte_role == rrsc_pkg::ROLE_PAYLOAD), "line done on control byte")
endmodule

bind raster_run_stream_checker rrsc_checker u_rrsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_out   (o_out.data_out),
    .i_byte_role  (o_out.byte_role),
    .i_line_done  (o_out.line_done),
    .i_page_done  (o_out.page_done),
    .i_error_code (o_out.error_code)
);
